/* rtl/core/sosp_pkg.sv */
package sosp_pkg;

   localparam int RANGE_W       = 16;
   localparam int BEAM_COUNT_W  = 13;
   localparam int SECTOR_W      = 12;
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 16;

   // Register indexes of the configuration port
   localparam logic [CSR_INDEX_W-1:0] CSR_BEAM_COUNT        = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RANGE_MIN_MM      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RANGE_MAX_MM      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_NEAR_THRESHOLD_MM = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRONT_HALF_WIDTH  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_SIDE_OUTER_WIDTH  = 3'd5;

   // Register reset values
   localparam logic [BEAM_COUNT_W-1:0] BEAM_COUNT_RESET        = 13'd360;
   localparam logic [RANGE_W-1:0]      RANGE_MIN_RESET         = 16'd0;
   localparam logic [RANGE_W-1:0]      RANGE_MAX_RESET         = 16'd65535;
   localparam logic [RANGE_W-1:0]      NEAR_THRESHOLD_RESET    = 16'd500;
   localparam logic [SECTOR_W-1:0]     FRONT_HALF_WIDTH_RESET  = 12'd15;
   localparam logic [SECTOR_W-1:0]     SIDE_OUTER_WIDTH_RESET  = 12'd55;

   typedef struct packed {
      logic [RANGE_W-1:0] range_mm;
      logic               is_finite;
   } req_payload_type;

   typedef struct packed {
      logic obstacle_ahead;
      logic turn_clockwise;
   } rsp_payload_type;

   // One classified beam, passed from the front end to the accumulator
   typedef struct packed {
      logic [RANGE_W-1:0] range_mm;
      logic               near_hit;
      logic               left_hit;
      logic               right_hit;
      logic               last;
   } beam_class_type;

endpackage

/* rtl/core/scan_obstacle_side_picker_unit.sv */
// Obstacle side picker: takes the range samples of one laser scan in beam order, one
// per clock while req_full is low, and after the last beam of each scan gives one
// result: whether a near valid sample lay in the front window, and the turn direction
// toward the side sector with the larger mean range (left on a tie, previous direction
// when nothing is near). The front end classifies each sample against the registers as
// it is accepted, so a register write takes effect from the next sample on; a four-entry
// queue separates it from the accumulator, which keeps the sector sums and then compares
// the means through two registered multipliers. Sustained rate is one sample per cycle
// with no gaps while the result side does not stall. Both queues hold four entries, so
// short stalls on the result side do not stop input.
module scan_obstacle_side_picker_unit
   import sosp_pkg::*;
#(
   parameter int MAX_BEAMS = 4096
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  req_payload_type        req_payload,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output rsp_payload_type        rsp_payload,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int MID_DEPTH = 4;
   localparam int OUT_DEPTH = 4;

   logic            mid_push, mid_full, mid_pop, mid_empty;
   beam_class_type  mid_wdata, mid_rdata;
   logic            out_push, out_full;
   rsp_payload_type out_wdata;

   assign req_full = mid_full;

   sosp_front #(
      .MAX_BEAMS (MAX_BEAMS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_payload (req_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .mid_full    (mid_full),
      .mid_push    (mid_push),
      .mid_data    (mid_wdata)
   );

   sosp_fifo #(
      .T     (beam_class_type),
      .DEPTH (MID_DEPTH)
   ) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_push),
      .push_data (mid_wdata),
      .full      (mid_full),
      .pop       (mid_pop),
      .pop_data  (mid_rdata),
      .empty     (mid_empty)
   );

   sosp_back #(
      .MAX_BEAMS (MAX_BEAMS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .mid_empty (mid_empty),
      .mid_data  (mid_rdata),
      .mid_pop   (mid_pop),
      .out_full  (out_full),
      .out_push  (out_push),
      .out_data  (out_wdata)
   );

   sosp_fifo #(
      .T     (rsp_payload_type),
      .DEPTH (OUT_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_wdata),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_payload),
      .empty     (rsp_empty)
   );

endmodule

/* rtl/core/sosp_fifo.sv */
module sosp_fifo
   import sosp_pkg::*;
#(
   parameter type T     = logic,
   parameter int  DEPTH = 4
) (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  T     push_data,
   output logic full,
   input  logic pop,
   output T     pop_data,
   output logic empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   T                 entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/core/sosp_front.sv */
module sosp_front
   import sosp_pkg::*;
#(
   parameter int MAX_BEAMS = 4096
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   input  req_payload_type        req_payload,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   mid_full,
   output logic                   mid_push,
   output beam_class_type         mid_data
);

   localparam int PW = $clog2(MAX_BEAMS);
   localparam int NW = PW + 1;
   localparam int BW = (NW > BEAM_COUNT_W) ? NW : BEAM_COUNT_W;
   localparam int SW = BW + 2;

   logic [BEAM_COUNT_W-1:0] beam_count_ff;
   logic [RANGE_W-1:0]      range_min_ff;
   logic [RANGE_W-1:0]      range_max_ff;
   logic [RANGE_W-1:0]      near_threshold_ff;
   logic [SECTOR_W-1:0]     front_half_width_ff;
   logic [SECTOR_W-1:0]     side_outer_width_ff;

   logic [PW-1:0]        pos_ff, pos_in;
   logic [BW-1:0]        bc_ext, n_sat;
   logic signed [SW-1:0] pos_s, n_s, c_s, fw_s, ow_s;
   logic                 sample_ok, in_front, in_left, in_right, last;
   logic                 accept;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         beam_count_ff       <= BEAM_COUNT_RESET;
         range_min_ff        <= RANGE_MIN_RESET;
         range_max_ff        <= RANGE_MAX_RESET;
         near_threshold_ff   <= NEAR_THRESHOLD_RESET;
         front_half_width_ff <= FRONT_HALF_WIDTH_RESET;
         side_outer_width_ff <= SIDE_OUTER_WIDTH_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_BEAM_COUNT:        beam_count_ff       <= csr_wdata[BEAM_COUNT_W-1:0];
            CSR_RANGE_MIN_MM:      range_min_ff        <= csr_wdata;
            CSR_RANGE_MAX_MM:      range_max_ff        <= csr_wdata;
            CSR_NEAR_THRESHOLD_MM: near_threshold_ff   <= csr_wdata;
            CSR_FRONT_HALF_WIDTH:  front_half_width_ff <= csr_wdata[SECTOR_W-1:0];
            CSR_SIDE_OUTER_WIDTH:  side_outer_width_ff <= csr_wdata[SECTOR_W-1:0];
            default: ;
         endcase
      end
   end

   // Scan length saturated to one..MAX_BEAMS
   always_comb begin
      bc_ext = BW'(beam_count_ff);
      if (bc_ext == '0) begin
         n_sat = BW'(1);
      end else if (bc_ext > BW'(MAX_BEAMS)) begin
         n_sat = BW'(MAX_BEAMS);
      end else begin
         n_sat = bc_ext;
      end
   end

   always_comb begin
      pos_s = $signed(SW'(pos_ff));
      n_s   = $signed(SW'(n_sat));
      c_s   = $signed(SW'(n_sat >> 1));
      fw_s  = $signed(SW'(front_half_width_ff));
      ow_s  = $signed(SW'(side_outer_width_ff));

      sample_ok = req_payload.is_finite
               && (req_payload.range_mm > range_min_ff)
               && (req_payload.range_mm < range_max_ff);
      in_front  = (pos_s >= c_s - fw_s) && (pos_s < c_s + fw_s);
      in_left   = (pos_s >= c_s + fw_s) && (pos_s < c_s + ow_s);
      in_right  = (pos_s >= c_s - ow_s) && (pos_s < c_s - fw_s);
      last      = (pos_s >= n_s - $signed(SW'(1)));
   end

   assign accept   = req_push && !mid_full;
   assign mid_push = accept;

   always_comb begin
      mid_data.range_mm  = req_payload.range_mm;
      mid_data.near_hit  = sample_ok && in_front && (req_payload.range_mm < near_threshold_ff);
      mid_data.left_hit  = sample_ok && in_left;
      mid_data.right_hit = sample_ok && in_right;
      mid_data.last      = last;
   end

   always_comb begin
      pos_in = pos_ff;
      if (accept) begin
         pos_in = last ? '0 : pos_ff + PW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

/* rtl/core/sosp_back.sv */
module sosp_back
   import sosp_pkg::*;
#(
   parameter int MAX_BEAMS = 4096
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            mid_empty,
   input  beam_class_type  mid_data,
   output logic            mid_pop,
   input  logic            out_full,
   output logic            out_push,
   output rsp_payload_type out_data
);

   localparam int CW    = $clog2(MAX_BEAMS);
   localparam int SUMW  = RANGE_W + CW;
   localparam int PRODW = SUMW + CW;

   logic [SUMW-1:0]  lsum_ff, lsum_in, rsum_ff, rsum_in, lsum_next, rsum_next;
   logic [CW-1:0]    lcnt_ff, lcnt_in, rcnt_ff, rcnt_in, lcnt_next, rcnt_next;
   logic             near_ff, near_in, near_next;

   logic             a_valid_ff, a_near_ff;
   logic [SUMW-1:0]  a_lsum_ff, a_rsum_ff;
   logic [CW-1:0]    a_lcnt_ff, a_rcnt_ff;
   logic [CW-1:0]    a_lcnt_nz, a_rcnt_nz;

   logic             b_valid_ff, b_near_ff;
   logic [PRODW-1:0] b_lprod_ff, b_rprod_ff;

   logic             turn_ff, turn_new;
   logic             advance, take_left, take_right;

   // Hold every stage while a finished result cannot enter the output queue
   assign advance    = !(b_valid_ff && out_full);
   assign mid_pop    = !mid_empty && advance;
   assign take_left  = mid_pop && mid_data.left_hit;
   assign take_right = mid_pop && mid_data.right_hit;

   always_comb begin
      lsum_next = lsum_ff + (take_left  ? SUMW'(mid_data.range_mm) : '0);
      rsum_next = rsum_ff + (take_right ? SUMW'(mid_data.range_mm) : '0);
      lcnt_next = lcnt_ff + CW'(take_left);
      rcnt_next = rcnt_ff + CW'(take_right);
      near_next = near_ff || (mid_pop && mid_data.near_hit);

      lsum_in = lsum_ff;
      rsum_in = rsum_ff;
      lcnt_in = lcnt_ff;
      rcnt_in = rcnt_ff;
      near_in = near_ff;
      if (mid_pop) begin
         if (mid_data.last) begin
            lsum_in = '0;
            rsum_in = '0;
            lcnt_in = '0;
            rcnt_in = '0;
            near_in = 1'b0;
         end else begin
            lsum_in = lsum_next;
            rsum_in = rsum_next;
            lcnt_in = lcnt_next;
            rcnt_in = rcnt_next;
            near_in = near_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lsum_ff <= '0;
         rsum_ff <= '0;
         lcnt_ff <= '0;
         rcnt_ff <= '0;
         near_ff <= 1'b0;
      end else begin
         lsum_ff <= lsum_in;
         rsum_ff <= rsum_in;
         lcnt_ff <= lcnt_in;
         rcnt_ff <= rcnt_in;
         near_ff <= near_in;
      end
   end

   // Snapshot of a finished scan
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= mid_pop && mid_data.last;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_lsum_ff <= lsum_next;
         a_rsum_ff <= rsum_next;
         a_lcnt_ff <= lcnt_next;
         a_rcnt_ff <= rcnt_next;
         a_near_ff <= near_next;
      end
   end

   // An empty sector compares as mean zero: its sum is zero, take count one
   assign a_lcnt_nz = (a_lcnt_ff == '0) ? CW'(1) : a_lcnt_ff;
   assign a_rcnt_nz = (a_rcnt_ff == '0) ? CW'(1) : a_rcnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (advance) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         b_lprod_ff <= PRODW'(a_lsum_ff) * PRODW'(a_rcnt_nz);
         b_rprod_ff <= PRODW'(a_rsum_ff) * PRODW'(a_lcnt_nz);
         b_near_ff  <= a_near_ff;
      end
   end

   // Turn right only when the right mean is strictly larger; keep direction without obstacle
   assign turn_new = b_near_ff ? (b_lprod_ff < b_rprod_ff) : turn_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         turn_ff <= 1'b0;
      end else if (advance && b_valid_ff) begin
         turn_ff <= turn_new;
      end
   end

   assign out_push = b_valid_ff && advance;

   always_comb begin
      out_data.obstacle_ahead = b_near_ff;
      out_data.turn_clockwise = turn_new;
   end

endmodule

/* dv/sosp_side_checker.sv */
`timescale 1ns / 100ps

module sosp_side_checker
   import sosp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   input  logic                   req_full,
   input  req_payload_type        req_payload,
   input  logic                   rsp_empty,
   input  logic                   rsp_pop,
   input  rsp_payload_type        rsp_payload,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     pending,
   output int                     failures,
   output int                     results_checked,
   output int                     obstacle_scans
);

   localparam int MAX_BEAMS = 4096;

   logic [BEAM_COUNT_W-1:0] scan_len_reg;
   logic [RANGE_W-1:0]      min_reg;
   logic [RANGE_W-1:0]      max_reg;
   logic [RANGE_W-1:0]      near_reg;
   logic [SECTOR_W-1:0]     front_reg;
   logic [SECTOR_W-1:0]     outer_reg;

   int                beam_pos;
   bit                near_flag;
   longint unsigned   left_sum;
   longint unsigned   right_sum;
   int unsigned       left_cnt;
   int unsigned       right_cnt;
   bit                heading_cw;
   rsp_payload_type   turn_q[$];

   task automatic clear_scan_sums();
      beam_pos  = 0;
      near_flag = 1'b0;
      left_sum  = 0;
      right_sum = 0;
      left_cnt  = 0;
      right_cnt = 0;
   endtask

   task automatic apply_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_BEAM_COUNT:        scan_len_reg = data[BEAM_COUNT_W-1:0];
         CSR_RANGE_MIN_MM:      min_reg      = data[RANGE_W-1:0];
         CSR_RANGE_MAX_MM:      max_reg      = data[RANGE_W-1:0];
         CSR_NEAR_THRESHOLD_MM: near_reg     = data[RANGE_W-1:0];
         CSR_FRONT_HALF_WIDTH:  front_reg    = data[SECTOR_W-1:0];
         CSR_SIDE_OUTER_WIDTH:  outer_reg    = data[SECTOR_W-1:0];
         default: ;
      endcase
   endtask

   // Fold one accepted beam into the running sector sums; close the scan on its last beam
   task automatic fold_beam(input req_payload_type beam);
      int              n;
      int              centre;
      int              fw;
      int              ow;
      bit              usable;
      longint unsigned lc;
      longint unsigned rc;
      rsp_payload_type verdict;
      n = int'(scan_len_reg);
      if (n < 1) n = 1;
      if (n > MAX_BEAMS) n = MAX_BEAMS;
      centre = n / 2;
      fw     = int'(front_reg);
      ow     = int'(outer_reg);
      usable = beam.is_finite && beam.range_mm > min_reg && beam.range_mm < max_reg;
      if (usable) begin
         if (beam_pos >= centre - fw && beam_pos < centre + fw && beam.range_mm < near_reg)
            near_flag = 1'b1;
         if (beam_pos >= centre + fw && beam_pos < centre + ow) begin
            left_sum += beam.range_mm;
            left_cnt++;
         end
         if (beam_pos >= centre - ow && beam_pos < centre - fw) begin
            right_sum += beam.range_mm;
            right_cnt++;
         end
      end
      if (beam_pos >= n - 1) begin
         if (near_flag) begin
            // compare means by cross-multiplication; an empty sector has mean zero
            lc = (left_cnt != 0) ? left_cnt : 1;
            rc = (right_cnt != 0) ? right_cnt : 1;
            heading_cw = (left_sum * rc >= right_sum * lc) ? 1'b0 : 1'b1;
         end
         verdict.obstacle_ahead = near_flag;
         verdict.turn_clockwise = heading_cw;
         turn_q.insert(turn_q.size(), verdict);
         clear_scan_sums();
      end else begin
         beam_pos++;
      end
   endtask

   task automatic check_turn(input rsp_payload_type got);
      rsp_payload_type want;
      if (turn_q.size() == 0) begin
         $error("unexpected result: obstacle_ahead=%0b turn_clockwise=%0b",
                got.obstacle_ahead, got.turn_clockwise);
         failures++;
      end else begin
         want = turn_q.pop_front();
         results_checked++;
         if (want.obstacle_ahead) obstacle_scans++;
         if (got.obstacle_ahead !== want.obstacle_ahead) begin
            $error("obstacle_ahead: expected %0b, got %0b",
                   want.obstacle_ahead, got.obstacle_ahead);
            failures++;
         end
         if (got.turn_clockwise !== want.turn_clockwise) begin
            $error("turn_clockwise: expected %0b, got %0b",
                   want.turn_clockwise, got.turn_clockwise);
            failures++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         scan_len_reg    = BEAM_COUNT_RESET;
         min_reg         = RANGE_MIN_RESET;
         max_reg         = RANGE_MAX_RESET;
         near_reg        = NEAR_THRESHOLD_RESET;
         front_reg       = FRONT_HALF_WIDTH_RESET;
         outer_reg       = SIDE_OUTER_WIDTH_RESET;
         heading_cw      = 1'b0;
         failures        = 0;
         results_checked = 0;
         obstacle_scans  = 0;
         clear_scan_sums();
         turn_q.delete();
      end else begin
         // a beam taken at this edge still sees the old registers
         if (req_push && !req_full) fold_beam(req_payload);
         if (rsp_pop && !rsp_empty) check_turn(rsp_payload);
         if (csr_valid && csr_ready) apply_csr(csr_index, csr_wdata);
      end
      pending <= turn_q.size();
   end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps

module testbench;
   import sosp_pkg::*;

   localparam int SETTLE_CYCLES = 16;
   localparam int HOLD_CYCLES   = 300;
   localparam int RANDOM_BEAMS  = 1580;

   // indexes beyond the register list; writes to them are dropped
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_A = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_B = 3'd7;

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_push    = 1'b0;
   logic                   req_full;
   req_payload_type        req_payload = '0;
   logic                   rsp_empty;
   logic                   rsp_pop     = 1'b0;
   rsp_payload_type        rsp_payload;
   logic                   csr_valid   = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index   = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata   = '0;

   int pending;
   int failures;
   int results_checked;
   int obstacle_scans;

   bit tx_burst    = 1'b0;
   bit rx_burst    = 1'b0;
   bit rx_hold_req = 1'b0;

   logic [RANGE_W-1:0] cur_min = RANGE_MIN_RESET;
   logic [RANGE_W-1:0] cur_max = RANGE_MAX_RESET;
   logic [RANGE_W-1:0] cur_thr = NEAR_THRESHOLD_RESET;
   int                 cur_len = int'(BEAM_COUNT_RESET);
   int                 beams_sent = 0;
   int                 csr_writes = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   scan_obstacle_side_picker_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_payload (req_payload),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   sosp_side_checker side_check (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_payload     (req_payload),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_payload     (rsp_payload),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .pending         (pending),
      .failures        (failures),
      .results_checked (results_checked),
      .obstacle_scans  (obstacle_scans)
   );

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx, input int data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(data);
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      csr_writes++;
      case (idx)
         CSR_BEAM_COUNT:        cur_len = int'(data[BEAM_COUNT_W-1:0]);
         CSR_RANGE_MIN_MM:      cur_min = data[RANGE_W-1:0];
         CSR_RANGE_MAX_MM:      cur_max = data[RANGE_W-1:0];
         CSR_NEAR_THRESHOLD_MM: cur_thr = data[RANGE_W-1:0];
         default: ;
      endcase
   endtask

   // Leave push high after a transfer so back-to-back beams need no extra edge
   task automatic send_beam(input logic [RANGE_W-1:0] r, input logic fin);
      int gap;
      gap = tx_burst ? 0 : $urandom_range(0, 11);
      repeat (gap) begin
         @(negedge clock);
         req_push <= 1'b0;
      end
      @(negedge clock);
      req_push    <= 1'b1;
      req_payload <= '{range_mm: r, is_finite: fin};
      do @(posedge clock); while (req_full);
      beams_sent++;
   endtask

   // Mostly near or in-range samples so that obstacles and sector sums both occur
   task automatic send_shaped_beam();
      int                 k;
      int                 lo;
      int                 hi;
      logic [RANGE_W-1:0] r;
      k  = $urandom_range(0, 99);
      lo = int'(cur_min) + 1;
      if (k < 35) begin
         hi = int'(cur_thr) - 1;
         r  = (hi >= lo) ? RANGE_W'($urandom_range(lo, hi)) : RANGE_W'($urandom_range(0, 65535));
      end else if (k < 45) begin
         case ($urandom_range(0, 7))
            0: r = '0;
            1: r = '1;
            2: r = cur_min;
            3: r = cur_max;
            4: r = cur_thr;
            5: r = cur_thr - 1'b1;
            6: r = cur_min + 1'b1;
            default: r = cur_max - 1'b1;
         endcase
      end else if (k < 85) begin
         hi = int'(cur_max) - 1;
         r  = (hi >= lo) ? RANGE_W'($urandom_range(lo, hi)) : RANGE_W'($urandom_range(0, 65535));
      end else begin
         r = RANGE_W'($urandom_range(0, 65535));
      end
      send_beam(r, $urandom_range(0, 9) != 0);
   endtask

   // Drop push, then hold until every predicted result has been popped and the pipe is empty
   task automatic wait_quiet();
      @(negedge clock);
      req_push <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic int scan_beams();
      if (cur_len < 1) return 1;
      if (cur_len > 4096) return 4096;
      return cur_len;
   endfunction

   task automatic random_phase(input bit write_all);
      int len;
      int fw;
      int ow;
      int scans;
      int items;
      int cut;
      case ($urandom_range(0, 19))
         0:       len = 0;
         1:       len = $urandom_range(100, 300);
         2:       len = 360;
         3:       len = 1;
         default: len = $urandom_range(2, 40);
      endcase
      case ($urandom_range(0, 7))
         0:       fw = $urandom_range(0, 65535);
         1:       fw = 0;
         default: fw = $urandom_range(0, len / 2 + 2);
      endcase
      case ($urandom_range(0, 7))
         0:       ow = $urandom_range(0, 65535);
         1:       ow = $urandom_range(0, fw & 'hFFF);
         default: ow = (fw & 'hFFF) + $urandom_range(0, len / 2 + 2);
      endcase
      if (write_all || $urandom_range(0, 2) != 0) csr_write(CSR_BEAM_COUNT, len);
      if (write_all || $urandom_range(0, 2) != 0) csr_write(CSR_FRONT_HALF_WIDTH, fw);
      if (write_all || $urandom_range(0, 2) != 0) csr_write(CSR_SIDE_OUTER_WIDTH, ow);
      if (write_all || $urandom_range(0, 2) != 0)
         case ($urandom_range(0, 9))
            0:       csr_write(CSR_RANGE_MIN_MM, 'hFFFF);
            1:       csr_write(CSR_RANGE_MIN_MM, $urandom_range(0, 65535));
            default: csr_write(CSR_RANGE_MIN_MM, $urandom_range(0, 50));
         endcase
      if (write_all || $urandom_range(0, 2) != 0)
         case ($urandom_range(0, 9))
            0:       csr_write(CSR_RANGE_MAX_MM, 0);
            1:       csr_write(CSR_RANGE_MAX_MM, $urandom_range(0, 65535));
            default: csr_write(CSR_RANGE_MAX_MM, $urandom_range(60000, 65535));
         endcase
      if (write_all || $urandom_range(0, 2) != 0)
         case ($urandom_range(0, 9))
            0:       csr_write(CSR_NEAR_THRESHOLD_MM, 0);
            1:       csr_write(CSR_NEAR_THRESHOLD_MM, 'hFFFF);
            2:       csr_write(CSR_NEAR_THRESHOLD_MM, $urandom_range(0, 65535));
            default: csr_write(CSR_NEAR_THRESHOLD_MM, $urandom_range(100, 3000));
         endcase
      if ($urandom_range(0, 9) == 0)
         csr_write($urandom_range(0, 1) ? CSR_SPARE_A : CSR_SPARE_B, $urandom_range(0, 65535));
      tx_burst = ($urandom_range(0, 3) == 0);
      scans    = $urandom_range(1, 5);
      repeat (scans) begin
         items = scan_beams();
         if (items > 2 && $urandom_range(0, 7) == 0) begin
            // stop part way, then shorten the scan under the partly filled sums
            cut = $urandom_range(1, items - 1);
            repeat (cut) send_shaped_beam();
            wait_quiet();
            csr_write(CSR_BEAM_COUNT, $urandom_range(1, items));
         end else begin
            repeat (items) send_shaped_beam();
         end
      end
   endtask

   initial begin
      int random_start;
      bit opening;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // six-beam scans: centre 3, front beams 2..3, left beam 4, right beam 1
      csr_write(CSR_BEAM_COUNT, 6);
      csr_write(CSR_FRONT_HALF_WIDTH, 1);
      csr_write(CSR_SIDE_OUTER_WIDTH, 2);
      // equal side means with an obstacle: turn left
      send_beam(16'hFFFF, 1'b1); send_beam(300, 1'b1); send_beam(0, 1'b1);
      send_beam(499, 1'b1);      send_beam(300, 1'b1); send_beam(16'hFFFF, 1'b0);
      // nothing near: threshold itself and a non-finite sample do not count
      send_beam(20, 1'b1);  send_beam(400, 1'b1); send_beam(500, 1'b1);
      send_beam(10, 1'b0);  send_beam(900, 1'b1); send_beam(7, 1'b1);
      // empty left sector against a populated right one: turn right
      send_beam(1, 1'b1);    send_beam(30, 1'b1); send_beam(100, 1'b1);
      send_beam(5000, 1'b1); send_beam(0, 1'b1);  send_beam(3, 1'b1);
      // empty right sector against a populated left one: turn left
      send_beam(2, 1'b1);    send_beam(700, 1'b0); send_beam(800, 1'b1);
      send_beam(12, 1'b1);   send_beam(1, 1'b1);   send_beam(9, 1'b1);
      // zero scan length acts as one beam
      wait_quiet();
      csr_write(CSR_BEAM_COUNT, 0);
      send_beam(100, 1'b1);
      // spare indexes, then an outer edge inside the front window
      wait_quiet();
      csr_write(CSR_SPARE_A, 'hFFFF);
      csr_write(CSR_SPARE_B, 1);
      csr_write(CSR_BEAM_COUNT, 4);
      csr_write(CSR_FRONT_HALF_WIDTH, 3);
      csr_write(CSR_SIDE_OUTER_WIDTH, 1);
      send_beam(16'hFFFF, 1'b1); send_beam(200, 1'b1); send_beam(42, 1'b1); send_beam(7, 1'b1);

      // one-beam scans with the receiver held off: both queues fill and push stalls
      wait_quiet();
      csr_write(CSR_BEAM_COUNT, 1);
      csr_write(CSR_FRONT_HALF_WIDTH, 1);
      tx_burst    = 1'b1;
      rx_hold_req = 1'b1;
      repeat (40) send_shaped_beam();
      wait_quiet();

      // oversized count saturates to the longest scan, whose centre puts the full-width
      // front window over the first beams; then cut the scan short mid-way
      csr_write(CSR_BEAM_COUNT, 'hFFFF);
      csr_write(CSR_FRONT_HALF_WIDTH, 2048);
      csr_write(CSR_SIDE_OUTER_WIDTH, 'hFFFF);
      csr_write(CSR_NEAR_THRESHOLD_MM, 1500);
      repeat (100) send_shaped_beam();
      wait_quiet();
      csr_write(CSR_BEAM_COUNT, 50);
      send_shaped_beam();
      tx_burst = 1'b0;

      random_start = beams_sent;
      opening      = 1'b1;
      while (beams_sent < random_start + RANDOM_BEAMS) begin
         wait_quiet();
         random_phase(opening);
         opening = 1'b0;
      end

      wait_quiet();
      $display("Run covered %0d beams and %0d register writes,", beams_sent, csr_writes);
      $display("checking %0d scan results, %0d with an obstacle ahead.",
               results_checked, obstacle_scans);
      if (failures == 0 && pending == 0)
         $display("PASS scan_obstacle_side_picker_unit");
      else
         $display("FAIL scan_obstacle_side_picker_unit");
      $finish;
   end

   // result side: random pops, bursts without gaps, and one long hold-off on request
   initial begin
      int gap;
      wait (!reset);
      forever begin
         if (rx_hold_req) begin
            @(negedge clock);
            rsp_pop <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            rx_hold_req = 1'b0;
         end
         if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
         gap = rx_burst ? 0 : $urandom_range(0, 11);
         repeat (gap) begin
            @(negedge clock);
            rsp_pop <= 1'b0;
         end
         @(negedge clock);
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
      end
   end

   initial begin
      #1_000_000;
      $display("FAIL scan_obstacle_side_picker_unit");
      $finish;
   end

endmodule

/* scan_obstacle_side_picker_unit.f */
rtl/core/sosp_pkg.sv
rtl/core/sosp_fifo.sv
rtl/core/sosp_front.sv
rtl/core/sosp_back.sv
rtl/core/scan_obstacle_side_picker_unit.sv
dv/sosp_side_checker.sv
dv/testbench.sv
